// ===== hw/rtl/feal_variant_block_cipher_top_assert.svh =====
// Assertion macros for the FEAL-NX variant cipher block.
`ifndef FEAL_VARIANT_BLOCK_CIPHER_TOP_ASSERT_SVH
`define FEAL_VARIANT_BLOCK_CIPHER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FVC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define FVC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/fvc_pkg.sv =====
// Shared types, constants and round functions for the FEAL-NX variant cipher.
`default_nettype none
package fvc_pkg;
  localparam int unsigned Rounds  = 32;
  localparam int unsigned KsIter  = (Rounds + 1) / 2 + 4;
  localparam int unsigned NSub    = KsIter * 2;
  localparam int unsigned KsCntW  = $clog2(KsIter + 1);
  localparam int unsigned QDepth  = 2;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  // Classified item between front and back: direction plus whitened halves.
  typedef struct packed {
    logic        dec;
    logic [31:0] l;
    logic [31:0] r;
  } item_t;

  typedef logic [15:0] sub_arr_t [NSub];

  function automatic logic [7:0] sbox(input logic [7:0] x, input logic [7:0] y,
                                      input logic c);
    logic [7:0] t;
    t = x + y + {7'd0, c};
    return {t[5:0], t[7:6]};
  endfunction

  function automatic logic [31:0] key_fn(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] g0, g1, g2, g3;
    g1 = a[23:16] ^ a[31:24];
    g2 = a[15:8] ^ a[7:0];
    g1 = sbox(g1, g2 ^ b[31:24], 1'b1);
    g2 = sbox(g2, g1 ^ b[23:16], 1'b0);
    g0 = sbox(a[31:24], g1 ^ b[15:8], 1'b0);
    g3 = sbox(a[7:0], g2 ^ b[7:0], 1'b1);
    return {g0, g1, g2, g3};
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [15:0] sk);
    logic [7:0] g0, g1, g2, g3;
    g1 = r[23:16] ^ sk[15:8] ^ r[31:24];
    g2 = r[15:8] ^ sk[7:0] ^ r[7:0];
    g1 = sbox(g1, g2, 1'b0);
    g2 = sbox(g2, g1, 1'b1);
    g0 = sbox(r[31:24], g1, 1'b1);
    g3 = sbox(r[7:0], g2, 1'b0);
    return {g0, g1, g2, g3};
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/fvc_keysched.sv =====
// Key registers and iterative FEAL-NX key schedule, one fK step per cycle.
`default_nettype none
module fvc_keysched
  import fvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output sub_arr_t         sub_o,
  output logic             ready_o
);
  logic [31:0] k0_q, k1_q, k2_q, k3_q;
  logic [31:0] a_q, b_q, d_q, t;
  logic [KsCntW-1:0] cnt_q;
  logic [1:0] ph_q;
  logic [31:0] q;
  sub_arr_t sub_q;

  always_comb begin
    case (ph_q)
      2'd0:    q = k2_q ^ k3_q;
      2'd1:    q = k2_q;
      default: q = k3_q;
    endcase
    t = key_fn(a_q, b_q ^ d_q ^ q);
  end

  assign ready_o = (cnt_q == KsCntW'(KsIter));
  assign sub_o   = sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_q <= '0; k1_q <= '0; k2_q <= '0; k3_q <= '0;
      a_q <= '0; b_q <= '0; d_q <= '0;
      cnt_q <= '0; ph_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0: begin k0_q <= cfg_data_i; a_q <= cfg_data_i; b_q <= k1_q; end
        REG_KEY1: begin k1_q <= cfg_data_i; a_q <= k0_q; b_q <= cfg_data_i; end
        REG_KEY2: begin k2_q <= cfg_data_i; a_q <= k0_q; b_q <= k1_q; end
        default:  begin k3_q <= cfg_data_i; a_q <= k0_q; b_q <= k1_q; end
      endcase
      d_q <= '0; cnt_q <= '0; ph_q <= '0;
    end else if (!ready_o) begin
      d_q <= a_q; a_q <= b_q; b_q <= t;
      ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
      cnt_q <= cnt_q + KsCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cfg_we_i && !ready_o) begin
      for (int i = 0; i < KsIter; i++) begin
        if (cnt_q == KsCntW'(i)) begin
          sub_q[2*i]   <= t[31:16];
          sub_q[2*i+1] <= t[15:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fvc_front.sv =====
// Front end: accept items, whiten and classify, queue them for the rounds.
`default_nettype none
module fvc_front
  import fvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command_i,
  input  wire logic [31:0] block_lo_i,
  input  wire logic [31:0] block_hi_i,
  input  sub_arr_t         sub_i,
  input  wire logic        ks_ready_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output item_t            q_item_o
);
  item_t mem_q [QDepth];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  item_t it;
  logic [31:0] w0, w2, w4, w6;
  logic push, pop;

  always_comb begin
    w0 = {sub_i[Rounds],   sub_i[Rounds+1]};
    w2 = {sub_i[Rounds+2], sub_i[Rounds+3]};
    w4 = {sub_i[Rounds+4], sub_i[Rounds+5]};
    w6 = {sub_i[Rounds+6], sub_i[Rounds+7]};
    it.dec = command_i;
    if (command_i == CMD_ENC) begin
      it.l = block_lo_i ^ w0;
      it.r = (block_hi_i ^ w2) ^ (block_lo_i ^ w0);
    end else begin
      it.r = block_lo_i ^ w4;
      it.l = (block_hi_i ^ w6) ^ (block_lo_i ^ w4);
    end
  end

  assign in_ready  = ks_ready_i && (cnt_q != 2'(QDepth));
  assign push      = in_valid && in_ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= it;
  end

  `include "feal_variant_block_cipher_top_assert.svh"
  `FVC_ASSERT_IMP(a_no_over, clk_i, rst_ni, cnt_q == 2'(QDepth), !push)
  `FVC_ASSERT_IMP(a_no_under, clk_i, rst_ni, cnt_q == 2'd0, !pop)
endmodule
`default_nettype wire

// ===== hw/rtl/fvc_back.sv =====
// Back end: fully pipelined rounds, one per stage, then output whitening.
`default_nettype none
module fvc_back
  import fvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  item_t            q_item_i,
  input  sub_arr_t         sub_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_lo_o,
  output logic [31:0]      result_hi_o
);
  item_t st_q [Rounds+1];
  logic [Rounds:0] v_q;
  logic adv;
  logic [31:0] w0, w2, w4, w6, l, r;

  // The whole pipe moves together; stall when the last stage holds an untaken item.
  assign adv       = !v_q[Rounds] || out_ready;
  assign q_ready_o = adv;
  assign out_valid = v_q[Rounds];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Rounds-1:0], q_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= q_item_i;
      for (int s = 0; s < Rounds; s++) begin
        st_q[s+1].dec <= st_q[s].dec;
        if (!st_q[s].dec) begin
          st_q[s+1].l <= st_q[s].r;
          st_q[s+1].r <= st_q[s].l ^ round_fn(st_q[s].r, sub_i[s]);
        end else begin
          st_q[s+1].r <= st_q[s].l;
          st_q[s+1].l <= st_q[s].r ^ round_fn(st_q[s].l, sub_i[Rounds-1-s]);
        end
      end
    end
  end

  always_comb begin
    w0 = {sub_i[Rounds],   sub_i[Rounds+1]};
    w2 = {sub_i[Rounds+2], sub_i[Rounds+3]};
    w4 = {sub_i[Rounds+4], sub_i[Rounds+5]};
    w6 = {sub_i[Rounds+6], sub_i[Rounds+7]};
    l = st_q[Rounds].l;
    r = st_q[Rounds].r;
    if (!st_q[Rounds].dec) begin
      result_lo_o = r ^ w4;
      result_hi_o = l ^ r ^ w6;
    end else begin
      result_lo_o = l ^ w0;
      result_hi_o = r ^ l ^ w2;
    end
  end

  `include "feal_variant_block_cipher_top_assert.svh"
  `FVC_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `FVC_ASSERT_IMP(a_take, clk_i, rst_ni, q_valid_i && q_ready_o, adv)
endmodule
`default_nettype wire

// ===== hw/rtl/feal_variant_block_cipher_top.sv =====
// Top level of the FEAL-NX variant block cipher engine.
// Usage:
//  - Write the four key words through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
//    Each write restarts the key schedule, one fK iteration per cycle, so the
//    input stays not ready until the schedule is done after the last write.
//  - Input channel in_valid/in_ready carries command_i (0 encrypt, 1 decrypt)
//    and the block words; an item moves when both are high.
//  - The front whitens each item and puts it in a two-entry queue; the back
//    is an input register followed by 32 round stages, one Feistel round each.
//  - An item goes through queue, input register and round stages to out_valid.
//  - Throughput: one item per cycle while out_ready is high.
//  - A stalled receiver freezes the whole round pipeline; the queue absorbs
//    the item in flight and then in_ready drops. Results stay held and stable.
//  - Reset clears the keys to zero, reruns the schedule and empties queue
//    and pipeline.
`default_nettype none
module feal_variant_block_cipher_top
  import fvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command_i,
  input  wire logic [31:0] block_lo_i,
  input  wire logic [31:0] block_hi_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_lo_o,
  output logic [31:0]      result_hi_o
);
  sub_arr_t sub;
  logic ks_ready, q_valid, q_ready;
  item_t q_item;

  // The user, not the block, keeps subkeys stable while items are in flight.
  fvc_keysched u_ks (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .sub_o(sub), .ready_o(ks_ready)
  );

  fvc_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .command_i, .block_lo_i, .block_hi_i,
    .sub_i(sub), .ks_ready_i(ks_ready),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  fvc_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .sub_i(sub), .out_valid, .out_ready, .result_lo_o, .result_hi_o
  );

  `include "feal_variant_block_cipher_top_assert.svh"
  `FVC_ASSERT_IMP(a_ks_gate, clk_i, rst_ni, !ks_ready, !in_ready)
endmodule
`default_nettype wire
